>>> rtl/core/naf_pkg.sv
// shared types and constants for the 3x3 neighbour mean filter
// no dependencies
`timescale 1ns / 1ps

package naf_pkg;

    localparam int PIX_W        = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MIN_DIM      = 2;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int OUT_ROW_W    = $clog2(MAX_HEIGHT);
    localparam int IN_ROW_W     = OUT_ROW_W + 1;
    localparam int SUM_W        = PIX_W + 3;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CNT_THREE,
        CNT_FIVE,
        CNT_EIGHT
    } cnt_code_t;

    typedef struct packed {
        logic               has_pix;
        logic [PIX_W-1:0]   pix;
        logic [COL_W-1:0]   col;
        logic               emit;
        logic               top;
        logic               bottom;
        logic               left;
        logic               right;
        logic               last;
    } naf_item_t;

    typedef struct packed {
        logic               valid;
        logic [SUM_W-1:0]   sum;
        cnt_code_t          cnt;
        logic               last;
    } naf_sum_t;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0]  width;
        logic [HEIGHT_REG_W-1:0] height;
        logic [COL_W-1:0]        in_col;
        logic [IN_ROW_W-1:0]     in_row;
        logic [COL_W-1:0]        out_col;
        logic [OUT_ROW_W-1:0]    out_row;
    } naf_stat_t;

endpackage

>>> rtl/core/naf_pix_if.sv
// pixel input channel: valid/ready handshake with pixel and drain flag
// depends on naf_pkg
`timescale 1ns / 1ps

interface naf_pix_if;
    import naf_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_value;
    logic               drain;

    modport source (output valid, output pixel_value, output drain, input ready);
    modport sink (input valid, input pixel_value, input drain, output ready);
endinterface

>>> rtl/core/naf_res_if.sv
// result output channel: valid/ready handshake with filtered value and frame end flag
// depends on naf_pkg
`timescale 1ns / 1ps

interface naf_res_if;
    import naf_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   filtered_value;
    logic               frame_last;

    modport source (output valid, output filtered_value, output frame_last, input ready);
    modport sink (input valid, input filtered_value, input frame_last, output ready);
endinterface

>>> rtl/core/naf_ctrl.sv
// frame size registers, input and output position counters, per-transfer decode
// depends on naf_pkg
`timescale 1ns / 1ps

module naf_ctrl
    import naf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   accept,
    input  logic [PIX_W-1:0]       pixel_value,
    input  logic                   drain,
    output logic                   item_valid,
    output naf_item_t              item,
    output naf_stat_t              stat
);

    logic [WIDTH_REG_W-1:0]  width_reg,   width_next;
    logic [HEIGHT_REG_W-1:0] height_reg,  height_next;
    logic [COL_W-1:0]        in_col_reg,  in_col_next;
    logic [IN_ROW_W-1:0]     in_row_reg,  in_row_next;
    logic [COL_W-1:0]        out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0]    out_row_reg, out_row_next;

    logic                    has_pix;
    logic                    skip;
    logic                    emit;
    logic                    in_wrap;
    logic                    top, bottom, left, right, last;
    logic [WIDTH_REG_W-1:0]  cfg_w;
    logic [HEIGHT_REG_W-1:0] cfg_h;

    always_comb
    begin
        cfg_w = cfg_data[WIDTH_REG_W-1:0];
        if (cfg_w < WIDTH_REG_W'(MIN_DIM))
        begin
            cfg_w = WIDTH_REG_W'(MIN_DIM);
        end
        else if (cfg_w > WIDTH_REG_W'(MAX_WIDTH))
        begin
            cfg_w = WIDTH_REG_W'(MAX_WIDTH);
        end
        cfg_h = cfg_data[HEIGHT_REG_W-1:0];
        if (cfg_h < HEIGHT_REG_W'(MIN_DIM))
        begin
            cfg_h = HEIGHT_REG_W'(MIN_DIM);
        end
        else if (cfg_h > HEIGHT_REG_W'(MAX_HEIGHT))
        begin
            cfg_h = HEIGHT_REG_W'(MAX_HEIGHT);
        end
    end

    always_comb
    begin
        has_pix = in_row_reg < IN_ROW_W'(height_reg);
        skip    = has_pix && drain;
        emit    = (in_row_reg >= IN_ROW_W'(2))
                  || ((in_row_reg == IN_ROW_W'(1)) && (in_col_reg != '0));
        in_wrap = (WIDTH_REG_W'(in_col_reg) + WIDTH_REG_W'(1)) >= width_reg;
        top     = out_row_reg != '0;
        bottom  = (HEIGHT_REG_W'(out_row_reg) + HEIGHT_REG_W'(1)) < height_reg;
        left    = out_col_reg != '0;
        right   = (WIDTH_REG_W'(out_col_reg) + WIDTH_REG_W'(1)) < width_reg;
        last    = !bottom && !right;
    end

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_w;
                REG_IMAGE_HEIGHT: height_next = cfg_h;
                default:          width_next  = width_reg;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept && !skip)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IN_ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (!right)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OUT_ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_REG_W'(RESET_WIDTH);
            height_reg  <= HEIGHT_REG_W'(RESET_HEIGHT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_comb
    begin
        item_valid   = accept && !skip;
        item.has_pix = has_pix;
        item.pix     = has_pix ? pixel_value : '0;
        item.col     = in_col_reg;
        item.emit    = emit;
        item.top     = top;
        item.bottom  = bottom;
        item.left    = left;
        item.right   = right;
        item.last    = last;
        stat.width   = width_reg;
        stat.height  = height_reg;
        stat.in_col  = in_col_reg;
        stat.in_row  = in_row_reg;
        stat.out_col = out_col_reg;
        stat.out_row = out_row_reg;
    end

endmodule

>>> rtl/core/naf_window.sv
// two line stores, 3x3 window and masked neighbour sum
// depends on naf_pkg
`timescale 1ns / 1ps

module naf_window
    import naf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      item_valid,
    input  naf_item_t item,
    output naf_sum_t  sum_out
);

    logic [PIX_W-1:0] above_mem [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] mid_mem   [0:MAX_WIDTH-1];

    logic [PIX_W-1:0] rd_above_reg;
    logic [PIX_W-1:0] rd_mid_reg;
    logic             a_valid_reg;
    naf_item_t        a_item_reg;

    logic [PIX_W-1:0] win_reg  [0:8];
    logic [PIX_W-1:0] win_next [0:8];
    logic [PIX_W-1:0] term     [0:7];
    logic [SUM_W-1:0] sum_next;
    cnt_code_t        cnt_next;
    logic             wr_en;

    logic             b_valid_reg;
    logic [SUM_W-1:0] b_sum_reg;
    cnt_code_t        b_cnt_reg;
    logic             b_last_reg;

    assign wr_en = en && a_valid_reg && a_item_reg.has_pix;

    // line stores: read whenever the pipeline is enabled, written back from the registered item when it holds a pixel
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_above_reg <= above_mem[item.col];
            rd_mid_reg   <= mid_mem[item.col];
        end
        if (wr_en)
        begin
            above_mem[a_item_reg.col] <= rd_mid_reg;
            mid_mem[a_item_reg.col]   <= a_item_reg.pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= item_valid;
            b_valid_reg <= a_valid_reg && a_item_reg.emit;
        end
    end

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = rd_above_reg;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = rd_mid_reg;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = a_item_reg.pix;
    end

    // neighbours outside the frame contribute zero
    always_comb
    begin
        term[0] = (a_item_reg.top && a_item_reg.left)     ? win_next[0] : '0;
        term[1] = a_item_reg.top                          ? win_next[1] : '0;
        term[2] = (a_item_reg.top && a_item_reg.right)    ? win_next[2] : '0;
        term[3] = a_item_reg.left                         ? win_next[3] : '0;
        term[4] = a_item_reg.right                        ? win_next[5] : '0;
        term[5] = (a_item_reg.bottom && a_item_reg.left)  ? win_next[6] : '0;
        term[6] = a_item_reg.bottom                       ? win_next[7] : '0;
        term[7] = (a_item_reg.bottom && a_item_reg.right) ? win_next[8] : '0;
        sum_next = ((SUM_W'(term[0]) + SUM_W'(term[1])) + (SUM_W'(term[2]) + SUM_W'(term[3])))
                 + ((SUM_W'(term[4]) + SUM_W'(term[5])) + (SUM_W'(term[6]) + SUM_W'(term[7])));
        if (a_item_reg.top && a_item_reg.bottom && a_item_reg.left && a_item_reg.right)
        begin
            cnt_next = CNT_EIGHT;
        end
        else if (!(a_item_reg.top && a_item_reg.bottom)
                 && !(a_item_reg.left && a_item_reg.right))
        begin
            cnt_next = CNT_THREE;
        end
        else
        begin
            cnt_next = CNT_FIVE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= item;
            if (a_valid_reg)
            begin
                win_reg    <= win_next;
                b_sum_reg  <= sum_next;
                b_cnt_reg  <= cnt_next;
                b_last_reg <= a_item_reg.last;
            end
        end
    end

    always_comb
    begin
        sum_out.valid = b_valid_reg;
        sum_out.sum   = b_sum_reg;
        sum_out.cnt   = b_cnt_reg;
        sum_out.last  = b_last_reg;
    end

endmodule

>>> rtl/core/naf_divide.sv
// divide by neighbour count (3, 5 or 8) and hold the result register
// depends on naf_pkg
`timescale 1ns / 1ps

module naf_divide
    import naf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  naf_sum_t         sum_in,
    output logic             out_valid,
    output logic [PIX_W-1:0] filtered_value,
    output logic             frame_last
);

    localparam int PROD_W  = 2 * SUM_W;
    localparam int RECIP3  = 683;
    localparam int SHIFT3  = 11;
    localparam int RECIP5  = 1639;
    localparam int SHIFT5  = 13;
    localparam int SHIFT8  = 3;

    logic [PROD_W-1:0] prod3;
    logic [PROD_W-1:0] prod5;
    logic [PROD_W-1:0] quot3;
    logic [PROD_W-1:0] quot5;
    logic [SUM_W-1:0]  quot8;
    logic [PIX_W-1:0]  value_next;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  value_reg;
    logic              last_reg;

    // reciprocal multiply, exact over the sum range of each case
    always_comb
    begin
        prod3 = PROD_W'(sum_in.sum) * PROD_W'(RECIP3);
        prod5 = PROD_W'(sum_in.sum) * PROD_W'(RECIP5);
        quot3 = prod3 >> SHIFT3;
        quot5 = prod5 >> SHIFT5;
        quot8 = sum_in.sum >> SHIFT8;
        case (sum_in.cnt)
            CNT_THREE: value_next = quot3[PIX_W-1:0];
            CNT_FIVE:  value_next = quot5[PIX_W-1:0];
            CNT_EIGHT: value_next = quot8[PIX_W-1:0];
            default:   value_next = quot8[PIX_W-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sum_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && sum_in.valid)
        begin
            value_reg <= value_next;
            last_reg  <= sum_in.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = value_reg;
    assign frame_last     = last_reg;

endmodule

>>> rtl/core/neighbour_average_filter_3x3.sv
// top level of the 3x3 neighbour mean filter (centre excluded)
// depends on naf_pkg, naf_pix_if, naf_res_if, naf_ctrl, naf_window, naf_divide
`timescale 1ns / 1ps

// usage:
//   pix carries pixels in raster order, one per transfer; res carries one
//   filtered value per pixel in raster order, frame_last on the final one
//   after the last pixel of a frame, send drain transfers (drain = 1) until
//   the frame_last result appears: image_width + 1 of them; a drain sent
//   earlier is dropped, and any transfer after all pixels counts as a drain
//   cfg_we/cfg_index/cfg_data write image_width (0) or image_height (1) while
//   the block is idle; values are clamped and a write restarts the frame
//   throughput: one transfer per cycle on each side while res is not stalled
//   pipeline: the result for pixel k is produced by transfer
//   k + image_width + 1 and then passes the registered line store read,
//   window sum and divide stages before it appears on res
//   reset clears positions and the pipeline and sets 640 x 480; line store
//   contents are not cleared and need no clearing pass
//   when res stalls, the whole pipeline holds and pix.ready drops; ready
//   stays high while a held result is taken in the same cycle

module neighbour_average_filter_3x3
    import naf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    naf_pix_if.sink                pix,
    naf_res_if.source              res,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic      en;
    logic      accept;
    logic      item_valid;
    naf_item_t item;
    naf_stat_t stat;
    naf_sum_t  sum;

    assign en        = !res.valid || res.ready;
    assign pix.ready = en;
    assign accept    = pix.valid && en;

    naf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .pixel_value (pix.pixel_value),
        .drain       (pix.drain),
        .item_valid  (item_valid),
        .item        (item),
        .stat        (stat)
    );

    naf_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (item_valid),
        .item       (item),
        .sum_out    (sum)
    );

    naf_divide u_divide (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .sum_in         (sum),
        .out_valid      (res.valid),
        .filtered_value (res.filtered_value),
        .frame_last     (res.frame_last)
    );

    // column counters and the output row stay inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        WIDTH_REG_W'(stat.in_col) < stat.width && WIDTH_REG_W'(stat.out_col) < stat.width)
        else $error("column counter outside frame width");

    assert property (@(posedge clk) disable iff (!rst_n)
        HEIGHT_REG_W'(stat.out_row) < stat.height)
        else $error("output row outside frame height");

    // output position never runs ahead of input, input row at most height + 1
    assert property (@(posedge clk) disable iff (!rst_n)
        IN_ROW_W'(stat.out_row) <= stat.in_row
        && stat.in_row <= IN_ROW_W'(stat.height) + IN_ROW_W'(1))
        else $error("input and output positions out of step");

    // a stalled result freezes the pipeline, so no transfer is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |-> !accept && !item_valid)
        else $error("transfer taken during output stall");

endmodule

>>> tb/tb_neighbour_average_filter_3x3.sv
// testbench for the 3x3 neighbour mean filter: frames of pixels go in, each result is
// checked against an internal prediction of the window mean and the frame end flag
// depends on naf_pkg, naf_pix_if, naf_res_if and neighbour_average_filter_3x3
`timescale 1ns / 1ps

module tb_neighbour_average_filter_3x3;
    import naf_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] filtered_value;
        logic             frame_last;
    } mean_result_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_BRIGHT,
        FILL_DARK,
        FILL_EXTREME
    } fill_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    naf_pix_if pix ();
    naf_res_if res ();

    neighbour_average_filter_3x3 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // prediction state
    logic [PIX_W-1:0]        above_line [MAX_WIDTH];
    logic [PIX_W-1:0]        middle_line [MAX_WIDTH];
    logic [PIX_W-1:0]        window [9];
    logic [WIDTH_REG_W-1:0]  width_setting;
    logic [HEIGHT_REG_W-1:0] height_setting;
    int unsigned             in_col;
    int unsigned             in_row;
    int unsigned             out_col;
    int unsigned             out_row;
    bit                      frame_done;
    mean_result_t            pending_means [$];

    int error_count;
    int burst_left;
    bit sender_steady;
    bit receiver_steady;
    int hold_cycles;
    int counted_items;

    always #5 clk = ~clk;

    function automatic int unsigned frame_width();
        if (width_setting < MIN_DIM)
            return MIN_DIM;
        if (width_setting > MAX_WIDTH)
            return MAX_WIDTH;
        return width_setting;
    endfunction

    function automatic int unsigned frame_height();
        if (height_setting < MIN_DIM)
            return MIN_DIM;
        if (height_setting > MAX_HEIGHT)
            return MAX_HEIGHT;
        return height_setting;
    endfunction

    function automatic void restart_frame();
        int i;
        for (i = 0; i < 9; i++)
        begin
            window[i] = '0;
        end
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void predict_mean(input logic [PIX_W-1:0] value, input logic drain_bit);
        int unsigned      w;
        int unsigned      h;
        int unsigned      sum;
        int unsigned      count;
        int               r;
        int               c;
        bit               is_pixel;
        bit               emit;
        bit               top;
        bit               bottom;
        bit               left;
        bit               right;
        bit               use_tap;
        logic [PIX_W-1:0] above_old;
        logic [PIX_W-1:0] middle_old;
        logic [PIX_W-1:0] new_pix;
        mean_result_t     mean;
        w = frame_width();
        h = frame_height();
        is_pixel = (in_row < h);
        // drain before the last pixel is dropped
        if (is_pixel && drain_bit)
            return;
        above_old  = above_line[in_col];
        middle_old = middle_line[in_col];
        new_pix    = '0;
        if (is_pixel)
        begin
            new_pix             = value;
            above_line[in_col]  = middle_old;
            middle_line[in_col] = value;
        end
        for (r = 0; r < 3; r++)
        begin
            window[r * 3]     = window[r * 3 + 1];
            window[r * 3 + 1] = window[r * 3 + 2];
        end
        window[2] = above_old;
        window[5] = middle_old;
        window[8] = new_pix;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= w)
        begin
            in_col = 0;
            in_row++;
        end
        else
        begin
            in_col++;
        end
        if (!emit)
            return;
        top    = (out_row > 0);
        bottom = (out_row + 1 < h);
        left   = (out_col > 0);
        right  = (out_col + 1 < w);
        sum = 0;
        for (r = 0; r < 3; r++)
        begin
            for (c = 0; c < 3; c++)
            begin
                use_tap = !(r == 0 && !top) && !(r == 2 && !bottom)
                          && !(c == 0 && !left) && !(c == 2 && !right) && !(r == 1 && c == 1);
                if (use_tap)
                    sum += window[r * 3 + c];
            end
        end
        count = (1 + int'(top) + int'(bottom)) * (1 + int'(left) + int'(right)) - 1;
        mean.filtered_value = PIX_W'(sum / count);
        mean.frame_last     = (out_row + 1 == h) && (out_col + 1 == w);
        pending_means.push_back(mean);
        if (mean.frame_last)
        begin
            restart_frame();
            frame_done = 1'b1;
        end
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
        begin
            out_col++;
        end
    endfunction

    function automatic logic [PIX_W-1:0] fill_value(input fill_t fill);
        case (fill)
            FILL_BRIGHT:  return {PIX_W{1'b1}};
            FILL_DARK:    return {PIX_W{1'b0}};
            FILL_EXTREME: return {PIX_W{$urandom_range(0, 1) == 1}};
            default:      return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [PIX_W-1:0] value, input logic drain_bit);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (!sender_steady)
            begin
                gap = $urandom_range(1, 4);
                pix.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix.valid       <= 1'b1;
        pix.pixel_value <= value;
        pix.drain       <= drain_bit;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        predict_mean(value, drain_bit);
    endtask

    task automatic finish_input();
        int guard;
        pix.valid <= 1'b0;
        burst_left = 0;
        guard = 0;
        while (pending_means.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == REG_IMAGE_WIDTH)
            width_setting = data[WIDTH_REG_W-1:0];
        else
            height_setting = data[HEIGHT_REG_W-1:0];
        restart_frame();
    endtask

    // pixel_limit below the frame size leaves the frame unfinished
    task automatic send_frame(input int unsigned pixel_limit, input fill_t fill,
                              input int early_pct, input int late_pct);
        int unsigned sent;
        frame_done = 1'b0;
        sent = 0;
        while (sent < pixel_limit)
        begin
            if ($urandom_range(0, 99) < early_pct)
            begin
                send_item(PIX_W'($urandom), 1'b1);
            end
            else
            begin
                send_item(fill_value(fill), 1'b0);
                sent++;
                counted_items++;
            end
        end
        if (pixel_limit < frame_width() * frame_height())
            return;
        while (!frame_done)
        begin
            send_item(PIX_W'($urandom), !($urandom_range(0, 99) < late_pct));
            counted_items++;
        end
    endtask

    task automatic test_directed();
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
        frame_done = 1'b0;
        // early drain, full-scale frame, then a late pixel
        send_item(8'hA5, 1'b1);
        repeat (9) send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        while (!frame_done)
            send_item(8'h5A, 1'b1);
        finish_input();
        // dimensions below the minimum clamp to 2 x 2
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 1);
        frame_done = 1'b0;
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        while (!frame_done)
            send_item(8'hC3, 1'b1);
        finish_input();
    endtask

    task automatic test_frame_restart();
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 4);
        send_frame(12, FILL_RANDOM, 0, 0);
        finish_input();
        write_reg(REG_IMAGE_HEIGHT, 4);
        send_frame(20, FILL_RANDOM, 10, 50);
        finish_input();
    endtask

    task automatic test_frame_chain();
        int k;
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_HEIGHT, 3);
        for (k = 0; k < 3; k++)
        begin
            send_frame(12, fill_t'(k), 10, 50);
        end
        finish_input();
    endtask

    task automatic test_size_extremes();
        // oversized width clamps to the full line store, cut into the second row
        write_reg(REG_IMAGE_WIDTH, {CFG_DATA_W{1'b1}});
        write_reg(REG_IMAGE_HEIGHT, 3);
        send_frame(MAX_WIDTH + 40, FILL_RANDOM, 5, 0);
        finish_input();
        // undersized width and oversized height, cut early
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, {CFG_DATA_W{1'b1}});
        send_frame(64, FILL_EXTREME, 5, 0);
        finish_input();
    endtask

    task automatic test_backpressure();
        write_reg(REG_IMAGE_WIDTH, 16);
        write_reg(REG_IMAGE_HEIGHT, 6);
        sender_steady = 1'b1;
        hold_cycles = 400;
        send_frame(96, FILL_RANDOM, 0, 50);
        finish_input();
        sender_steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int          frames;
        int          k;
        bit          cut;
        counted_items = 0;
        while (counted_items < 350)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    w = $urandom_range(65, 128);
                    h = 2;
                end
                1, 2:
                begin
                    w = $urandom_range(17, 64);
                    h = $urandom_range(2, 4);
                end
                default:
                begin
                    w = $urandom_range(2, 16);
                    h = $urandom_range(2, 8);
                end
            endcase
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(REG_IMAGE_WIDTH, {2'($urandom), WIDTH_REG_W'(w)});
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            end
            else
            begin
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
                write_reg(REG_IMAGE_WIDTH, {2'($urandom), WIDTH_REG_W'(w)});
            end
            frames = $urandom_range(1, 3);
            cut = 1'b0;
            for (k = 0; k < frames && !cut && counted_items < 350; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_frame($urandom_range(1, w * h - 1), FILL_RANDOM, 10, 0);
                    cut = 1'b1;
                end
                else
                begin
                    send_frame(w * h, fill_t'($urandom_range(0, 3)), 10, 50);
                end
            end
            finish_input();
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        mean_result_t oldest;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_means.size() == 0)
            begin
                $error("result with no pending pixel: filtered_value %0d frame_last %0b",
                       res.filtered_value, res.frame_last);
                error_count++;
            end
            else
            begin
                oldest = pending_means.pop_front();
                if (res.filtered_value !== oldest.filtered_value)
                begin
                    $error("filtered_value: expected %0d, actual %0d",
                           oldest.filtered_value, res.filtered_value);
                    error_count++;
                end
                if (res.frame_last !== oldest.frame_last)
                begin
                    $error("frame_last: expected %0b, actual %0b",
                           oldest.frame_last, res.frame_last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : result_sink
        int run_len;
        int stall_len;
        res.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                res.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            run_len = $urandom_range(1, 24);
            res.ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (!receiver_steady)
            begin
                stall_len = $urandom_range(1, 6);
                res.ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : main
        int i;
        clk = 1'b0;
        rst_n = 1'b0;
        pix.valid       <= 1'b0;
        pix.pixel_value <= '0;
        pix.drain       <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        error_count     = 0;
        burst_left      = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        hold_cycles     = 0;
        counted_items   = 0;
        frame_done      = 1'b0;
        for (i = 0; i < MAX_WIDTH; i++)
        begin
            above_line[i]  = '0;
            middle_line[i] = '0;
        end
        width_setting  = WIDTH_REG_W'(RESET_WIDTH);
        height_setting = HEIGHT_REG_W'(RESET_HEIGHT);
        restart_frame();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_frame_restart();
        test_frame_chain();
        test_backpressure();
        test_size_extremes();
        test_random_frames();

        finish_input();
        if (pending_means.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_means.size());
            error_count++;
        end
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
